// ===== rtl/core/expression_tokenizer_macros.svh =====
// assertion helpers for the expression tokenizer
`ifndef EXPRESSION_TOKENIZER_MACROS_SVH
`define EXPRESSION_TOKENIZER_MACROS_SVH

// same-cycle implication, off while in reset
`define EXPTOK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define EXPTOK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/exptok_pkg.sv =====
`default_nettype none
package exptok_pkg;

  localparam int MAX_TEXT_DEF    = 1022;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int POS_WIDTH_DEF   = 16;
  localparam int KIND_W          = 4;
  localparam int PREFIX_W        = 32;

  // token kinds as they appear on the output
  typedef enum logic [KIND_W-1:0] {
    K_VAR     = 4'd0,
    K_NUM     = 4'd1,
    K_PLUS    = 4'd2,
    K_MINUS   = 4'd3,
    K_MULT    = 4'd4,
    K_DIV     = 4'd5,
    K_EXP     = 4'd6,
    K_LPAREN  = 4'd7,
    K_RPAREN  = 4'd8,
    K_SIN     = 4'd9,
    K_COS     = 4'd10,
    K_TAN     = 4'd11,
    K_SQRT    = 4'd12,
    K_EOF     = 4'd13,
    K_UNKNOWN = 4'd14
  } kind_t;

  // pending run mode
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_NUM  = 3'b010,
    MODE_NAME = 3'b100
  } mode_t;

  // how many words go into the result queue this cycle
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_MULT   = 8'h2a;
  localparam logic [7:0] CH_DIV    = 8'h2f;
  localparam logic [7:0] CH_EXP    = 8'h5e;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // first name bytes packed with the first byte lowest
  localparam logic [PREFIX_W-1:0] NAME_SIN  = 32'h006e6973;
  localparam logic [PREFIX_W-1:0] NAME_COS  = 32'h00736f63;
  localparam logic [PREFIX_W-1:0] NAME_TAN  = 32'h006e6174;
  localparam logic [PREFIX_W-1:0] NAME_SQRT = 32'h74727173;

  // single-character operator decode
  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_MULT:   k = K_MULT;
      CH_DIV:    k = K_DIV;
      CH_EXP:    k = K_EXP;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      default:   k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/expression_tokenizer.sv =====
`default_nettype none
// channel   direction  handshake           payload
// input     in         in_valid/in_ready   ch, end_marker
// result    out        out_valid/out_ready token_kind, start_offset, text_length,
//                                          number_value, number_overflow, last
//
// one character word is taken per cycle while in_ready is high; the run state updates in that cycle
// and the tokens it finishes, up to two, land in a four-word result queue.
// in_ready drops only when the queue holds more than two words, so a stream
// of two-token characters is paced by the queue's pop.
// reset is synchronous; it empties the queue and clears the run and position.
// a stalled result side fills the queue and then holds off new characters.
module expression_tokenizer import exptok_pkg::*; #(
  parameter int MAX_TEXT    = MAX_TEXT_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int POS_WIDTH   = POS_WIDTH_DEF,
  localparam int LEN_W      = $clog2(MAX_TEXT + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             ch,
  input  wire logic                   end_marker,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [KIND_W-1:0]           token_kind,
  output logic [POS_WIDTH-1:0]        start_offset,
  output logic [LEN_W-1:0]            text_length,
  output logic [VALUE_WIDTH-1:0]      number_value,
  output logic                        number_overflow,
  output logic                        last
);

`include "expression_tokenizer_macros.svh"

  localparam int TOK_W = KIND_W + POS_WIDTH + LEN_W + VALUE_WIDTH + 2;
  localparam logic [VALUE_WIDTH-1:0] VMAX = '1;

  // run state
  mode_t                  mode, mode_next;
  logic [PREFIX_W-1:0]    prefix, prefix_next;
  logic [LEN_W-1:0]       run_len, run_len_next;
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic                   acc_ovf, acc_ovf_next;
  logic [POS_WIDTH-1:0]   pos, pos_next;
  logic [POS_WIDTH-1:0]   run_start, run_start_next;

  logic                   accept;
  logic                   is_digit, is_alpha, is_space;
  logic                   cont;
  logic                   flush_en, second_en;
  kind_t                  flush_kind, second_kind, name_k;
  logic [POS_WIDTH-1:0]   second_start;
  logic [LEN_W-1:0]       second_len;
  logic [VALUE_WIDTH+3:0] wide;
  logic [LEN_W-1:0]       run_len_grown;
  logic [TOK_W-1:0]       flush_word, second_word, word_a, word_b, pop_word;
  push_t                  push;
  logic                   room;

  assign accept   = in_valid && in_ready;
  assign in_ready = room;

  // character classes
  always_comb begin
    is_digit = ch inside {[8'h30:8'h39]};
    is_alpha = ch inside {[8'h41:8'h5a], [8'h61:8'h7a]};
    is_space = ch inside {8'h20, [8'h09:8'h0d]};
  end

  // a character that extends the pending run
  assign cont = !end_marker &&
                (((mode == MODE_NUM) && is_digit) || ((mode == MODE_NAME) && is_alpha));

  // decimal accumulate, saturating
  assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (VALUE_WIDTH + 4)'(ch[3:0]);
  assign run_len_grown = (run_len < LEN_W'(MAX_TEXT)) ? run_len + LEN_W'(1) : run_len;

  // name kind once the run ends; a paren after it picks a function, or unknown if none matches
  always_comb begin
    name_k = K_VAR;
    if (!end_marker && (ch == CH_LPAREN)) begin
      if (run_len == LEN_W'(3) && prefix == NAME_SIN) begin
        name_k = K_SIN;
      end else if (run_len == LEN_W'(3) && prefix == NAME_COS) begin
        name_k = K_COS;
      end else if (run_len == LEN_W'(3) && prefix == NAME_TAN) begin
        name_k = K_TAN;
      end else if (run_len == LEN_W'(4) && prefix == NAME_SQRT) begin
        name_k = K_SQRT;
      end else begin
        name_k = K_UNKNOWN;
      end
    end
  end

  // tokens produced by this word
  always_comb begin
    flush_en     = !cont && ((mode == MODE_NUM) || (mode == MODE_NAME));
    flush_kind   = (mode == MODE_NUM) ? K_NUM : name_k;
    second_en    = end_marker || (!cont && !is_digit && !is_alpha && !is_space);
    second_kind  = end_marker ? K_EOF : single_kind(ch);
    second_start = pos;
    second_len   = end_marker ? '0 : LEN_W'(1);
  end

  // next run state
  always_comb begin
    mode_next      = mode;
    prefix_next    = prefix;
    run_len_next   = run_len;
    acc_next       = acc;
    acc_ovf_next   = acc_ovf;
    pos_next       = pos + POS_WIDTH'(1);
    run_start_next = run_start;
    if (end_marker) begin
      mode_next      = MODE_IDLE;
      prefix_next    = '0;
      run_len_next   = '0;
      acc_next       = '0;
      acc_ovf_next   = 1'b0;
      run_start_next = '0;
      pos_next       = '0;
    end else if (cont) begin
      run_len_next = run_len_grown;
      if (is_digit) begin
        if (acc_ovf || (wide[VALUE_WIDTH+3:VALUE_WIDTH] != 4'd0)) begin
          acc_next     = VMAX;
          acc_ovf_next = 1'b1;
        end else begin
          acc_next = wide[VALUE_WIDTH-1:0];
        end
      end else if (run_len < LEN_W'(4)) begin
        prefix_next = prefix | (PREFIX_W'(ch) << {run_len[1:0], 3'b000});
      end
    end else begin
      mode_next      = MODE_IDLE;
      prefix_next    = '0;
      run_len_next   = '0;
      acc_next       = '0;
      acc_ovf_next   = 1'b0;
      run_start_next = '0;
      if (is_digit) begin
        mode_next      = MODE_NUM;
        run_start_next = pos;
        run_len_next   = LEN_W'(1);
        acc_next       = VALUE_WIDTH'(ch[3:0]);
      end else if (is_alpha) begin
        mode_next      = MODE_NAME;
        run_start_next = pos;
        run_len_next   = LEN_W'(1);
        prefix_next    = PREFIX_W'(ch);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      prefix    <= '0;
      run_len   <= '0;
      acc       <= '0;
      acc_ovf   <= 1'b0;
      pos       <= '0;
      run_start <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      prefix    <= prefix_next;
      run_len   <= run_len_next;
      acc       <= acc_next;
      acc_ovf   <= acc_ovf_next;
      pos       <= pos_next;
      run_start <= run_start_next;
    end
  end

  // result words; the later one of the pair carries last
  always_comb begin
    flush_word  = {flush_kind, run_start, run_len,
                   (mode == MODE_NUM) ? acc : '0,
                   (mode == MODE_NUM) && acc_ovf, !second_en};
    second_word = {second_kind, second_start, second_len, {VALUE_WIDTH{1'b0}}, 1'b0, 1'b1};
    push.first  = accept && (flush_en || second_en);
    push.second = accept && flush_en && second_en;
    word_a      = flush_en ? flush_word : second_word;
    word_b      = second_word;
  end

  exptok_queue #(
    .DATA_W (TOK_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_a    (word_a),
    .data_b    (word_b),
    .room      (room),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (pop_word)
  );

  assign {token_kind, start_offset, text_length, number_value, number_overflow, last} =
    pop_word;

  // checks
  `EXPTOK_ASSERT_NEXT(a_eof_resets_pos, clk, rst, accept && end_marker, pos == '0, "position not cleared after end")
  `EXPTOK_ASSERT_NOW(a_idle_no_len, clk, rst, mode == MODE_IDLE, run_len == '0, "idle with nonzero run length")
  `EXPTOK_ASSERT_NOW(a_ovf_saturated, clk, rst, acc_ovf, acc == VMAX, "overflow flag without saturated value")
  `EXPTOK_ASSERT_NOW(a_break_flushes, clk, rst, accept && !end_marker && mode == MODE_NUM && !is_digit, push.first, "number run ended without a token")

endmodule
`default_nettype wire

// ===== rtl/core/exptok_queue.sv =====
`default_nettype none
module exptok_queue import exptok_pkg::*; #(
  parameter int DATA_W = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire push_t             push,
  input  wire logic [DATA_W-1:0] data_a,
  input  wire logic [DATA_W-1:0] data_b,
  output logic                   room,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              pop;
  logic [1:0]        n_push;

  assign pop       = pop_valid && pop_ready;
  assign n_push    = {1'b0, push.first} + {1'b0, push.second};
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];
  // room for the two words one item can produce
  assign room      = (count <= CNT_W'(DEPTH - 2));

  always_comb begin
    count_next = count + CNT_W'(n_push) - CNT_W'(pop);
  end

  // slot writes, first word at the write pointer
  always_ff @(posedge clk) begin
    if (push.first) begin
      slots[wr_ptr] <= data_a;
    end
    if (push.second) begin
      slots[wr_ptr + PTR_W'(1)] <= data_b;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule
`default_nettype wire
